// ===== design/fit_mode_block_allocator_core_assert.svh =====
// Assertion macros for the block allocator
`ifndef FIT_MODE_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIT_MODE_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define FBA_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication
`define FBA_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== design/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants and types of the fit mode block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fba_pkg;
    localparam int ARENA_BYTES_DEF  = 65536;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int MAX_BLOCKS_DEF   = 256;
    localparam int FIELD_W          = 17;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_INSERT,
        S_REL_RD, S_REL_CHK, S_OUT
    } state_t;

    // memory access from the sequencer
    typedef struct packed {
        logic        rd_en;
        logic [10:0] rd_addr;
        logic        wr_en;
        logic [10:0] wr_addr;
    } mem_ctl_t;
endpackage

// ===== design/fba_table_mem.sv =====
// ----------------------------------------------------------------------------
// fba_table_mem
// Block table: start and length per entry, one read and one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fba_table_mem #(
    parameter int DEPTH = fba_pkg::MAX_BLOCKS_DEF,
    parameter int AW    = 8,
    parameter int SW    = 16,
    parameter int LW    = 17
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [SW-1:0] rd_start,
    output logic [LW-1:0] rd_len,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [SW-1:0] wr_start,
    input  logic [LW-1:0] wr_len
);
    import fba_pkg::*;
    logic [SW+LW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_start, wr_len};
        end
        if (rd_en)
        begin
            {rd_start, rd_len} <= mem[rd_addr];
        end
    end
endmodule

// ===== design/fit_mode_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fit_mode_block_allocator_core
// Arena allocator with first, best and worst fit over a sorted block table.
// ----------------------------------------------------------------------------
// Steps: allocate scans the gaps (up to n+1), shifts the entries above the
// pick up, then takes the insert and output steps; release searches for the
// block, shifts the entries above it down, then takes the output step; n live
// blocks. The table memory's single read port sets the pace.
// One item at a time; the result waits in an output register.
// Reset clears the live count, fit mode and control; table contents stay.
`timescale 1ns / 1ps
module fit_mode_block_allocator_core #(
    parameter int ARENA_BYTES  = fba_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = fba_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = fba_pkg::MAX_BLOCKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [16:0] request_size, [33:17] release_address, [39:34] zero
    input  logic [39:0] s_axis_tdata,
    // [0] command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [16:0] user_address, [33:17] granted_size, [39:34] zero
    output logic [39:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    import fba_pkg::*;
    `include "fit_mode_block_allocator_core_assert.svh"

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = (ARENA_BYTES > 2) ? $clog2(ARENA_BYTES) : 1;
    localparam int LW = SW + 1;
    localparam int WW = (LW > FIELD_W ? LW : FIELD_W) + 2;
    localparam logic [WW-1:0] ARENA_W = WW'(ARENA_BYTES);
    localparam logic [WW-1:0] HDR_W   = WW'(HEADER_BYTES);

    state_t state_reg, state_next;
    logic [1:0]    mode_reg;
    logic [CW-1:0] live_reg, live_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pick_reg, pick_next;
    logic          found_reg, found_next;
    logic [WW-1:0] need_reg, need_next, pstart_reg, pstart_next, psize_reg, psize_next;
    logic [WW-1:0] prev_end_reg, prev_end_next;
    logic [FIELD_W-1:0] addr_reg, addr_next;
    logic [1:0]    ost_reg, ost_next;
    logic [FIELD_W-1:0] oaddr_reg, oaddr_next, osize_reg, osize_next;
    logic          ovalid_reg, ovalid_next;

    mem_ctl_t mc;
    logic [SW-1:0] rd_start, wr_start;
    logic [LW-1:0] rd_len, wr_len;

    fba_table_mem #(.DEPTH(MAX_BLOCKS), .AW(AW), .SW(SW), .LW(LW)) u_mem (
        .clk(clk), .rd_en(mc.rd_en), .rd_addr(mc.rd_addr[AW-1:0]),
        .rd_start(rd_start), .rd_len(rd_len), .wr_en(mc.wr_en),
        .wr_addr(mc.wr_addr[AW-1:0]), .wr_start(wr_start), .wr_len(wr_len)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = ost_reg;
    assign m_axis_tdata  = {6'd0, osize_reg, oaddr_reg};

    logic [WW-1:0] gs, ge, gsz, rd_end, rel_hit;
    logic          take;

    always_comb
    begin
        state_next = state_reg; live_next = live_reg; idx_next = idx_reg;
        pick_next = pick_reg; found_next = found_reg; need_next = need_reg;
        pstart_next = pstart_reg; psize_next = psize_reg;
        prev_end_next = prev_end_reg; addr_next = addr_reg;
        ost_next = ost_reg; oaddr_next = oaddr_reg; osize_next = osize_reg;
        ovalid_next = ovalid_reg;
        mc = '0; wr_start = '0; wr_len = '0;
        rd_end = WW'(rd_start) + WW'(rd_len);
        gs = prev_end_reg;
        ge = (idx_reg < live_reg) ? WW'(rd_start) : ARENA_W;
        gsz = (ge > gs) ? ge - gs : '0;
        take = 1'b0;
        rel_hit = WW'(rd_start) + HDR_W;
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    need_next = WW'(s_axis_tdata[16:0]) + HDR_W;
                    addr_next = s_axis_tdata[33:17];
                    idx_next = '0; found_next = 1'b0; prev_end_next = '0;
                    oaddr_next = '0; osize_next = '0;
                    if (s_axis_tuser == CMD_RELEASE)
                    begin
                        state_next = (live_reg == '0) ? S_OUT : S_REL_RD;
                        ost_next = ST_IGNORED;
                    end
                    else if (live_reg == CW'(MAX_BLOCKS))
                    begin
                        ost_next = ST_FULL; state_next = S_OUT;
                    end
                    else
                    begin
                        // mark the transaction as an allocate for the shift steps
                        ost_next = ST_DONE;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                mc.rd_en = 1'b1; mc.rd_addr = 11'(idx_reg);
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (gsz >= need_reg)
                begin
                    if (!found_reg) take = 1'b1;
                    else if (mode_reg == MODE_BEST) take = gsz < psize_reg;
                    else take = gsz > psize_reg;
                end
                if (take)
                begin
                    found_next = 1'b1; pick_next = idx_reg;
                    pstart_next = gs; psize_next = gsz;
                end
                prev_end_next = rd_end;
                idx_next = idx_reg + 1'b1;
                if ((take && mode_reg == MODE_FIRST) || idx_reg == live_reg)
                begin
                    if (!(found_reg || take))
                    begin
                        ost_next = ST_NOFIT; state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next = live_reg;
                        state_next = (live_reg == (take ? idx_reg : pick_reg))
                                     ? S_INSERT : S_SHIFT_RD;
                    end
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                // alloc: move idx-1 to idx; release: move idx+1 to idx
                mc.rd_en = 1'b1;
                mc.rd_addr = (ost_reg == ST_IGNORED) ? 11'(idx_reg + 1'b1)
                                                     : 11'(idx_reg - 1'b1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                mc.wr_en = 1'b1; mc.wr_addr = 11'(idx_reg);
                wr_start = rd_start; wr_len = rd_len;
                if (ost_reg == ST_IGNORED)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 2'd2 >= live_reg)
                    begin
                        live_next = live_reg - 1'b1;
                        ost_next = ST_DONE; state_next = S_OUT;
                    end
                    else state_next = S_SHIFT_RD;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                    state_next = (idx_reg - 1'b1 == pick_reg) ? S_INSERT : S_SHIFT_RD;
                end
            end
            S_INSERT:
            begin
                mc.wr_en = 1'b1; mc.wr_addr = 11'(pick_reg);
                wr_start = SW'(pstart_reg);
                if (psize_reg < need_reg + HDR_W)
                    wr_len = LW'(psize_reg);
                else
                    wr_len = LW'(need_reg);
                live_next = live_reg + 1'b1;
                ost_next = ST_DONE;
                oaddr_next = FIELD_W'(pstart_reg + HDR_W);
                osize_next = FIELD_W'(wr_len);
                state_next = S_OUT;
            end
            S_REL_RD:
            begin
                mc.rd_en = 1'b1; mc.rd_addr = 11'(idx_reg);
                state_next = S_REL_CHK;
            end
            S_REL_CHK:
            begin
                if (rel_hit == WW'(addr_reg))
                begin
                    if (idx_reg + 1'b1 >= live_reg)
                    begin
                        live_next = live_reg - 1'b1;
                        ost_next = ST_DONE; state_next = S_OUT;
                    end
                    else state_next = S_SHIFT_RD;
                end
                else if (idx_reg + 1'b1 >= live_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1; state_next = S_REL_RD;
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; mode_reg <= '0; live_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; live_reg <= live_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready) mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; pick_reg <= pick_next; found_reg <= found_next;
        need_reg <= need_next; pstart_reg <= pstart_next; psize_reg <= psize_next;
        prev_end_reg <= prev_end_next; addr_reg <= addr_next;
        ost_reg <= ost_next; oaddr_reg <= oaddr_next; osize_reg <= osize_next;
    end

    `FBA_ASSERT_IMP(a_live_bound, clk, rst_n, 1'b1, live_reg <= CW'(MAX_BLOCKS),
        "live count past table depth")
    `FBA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE,
        !s_axis_tready, "input accepted while busy")
    `FBA_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tuser), "result dropped while stalled")
endmodule
